FILE: rtl/bdqd_pkg.sv
// ----------------------------------------------------------------------------
// bdqd_pkg
// Shared types, constants and the quadrature step table for the button
// debounce and quadrature decode unit.
// ----------------------------------------------------------------------------
package bdqd_pkg;

  // Default sizing of the unit.
  localparam int unsigned TIME_BITS_DEF    = 32;
  localparam int unsigned BUTTON_COUNT_DEF = 3;

  // Number of button level pins on the request.
  localparam int unsigned LEVEL_INPUTS = 3;

  // Configuration defaults after reset.
  localparam logic [15:0] DEBOUNCE_RESET = 16'd50;
  localparam logic [15:0] LONG_RESET     = 16'd1000;

  // Register indexes, decoded from the word address.
  localparam logic REG_DEBOUNCE = 1'b0;
  localparam logic REG_LONG     = 1'b1;

  // Step sum thresholds that complete one detent.
  localparam logic signed [3:0] DETENT_UP   = 4'sd4;
  localparam logic signed [3:0] DETENT_DOWN = -4'sd4;

  // Detent counter limits.
  localparam logic signed [7:0] COUNT_MAX = 8'sd127;
  localparam logic signed [7:0] COUNT_MIN = -8'sd128;

  // Button event codes.
  typedef enum logic [1:0] {
    EVT_NONE  = 2'd0,
    EVT_SHORT = 2'd1,
    EVT_LONG  = 2'd2
  } evt_e;

  // What one button lane reports for the current request.
  typedef struct packed {
    logic act;
    evt_e evt;
  } lane_stat_t;

  // What the encoder lane reports for the current request.
  typedef struct packed {
    logic             act;
    logic signed [7:0] count;
  } quad_stat_t;

  // Step value for a transition from the previous to the current contact
  // pair, indexed by {prev, cur}. An invalid jump gives zero.
  function automatic logic signed [1:0] quad_step(input logic [3:0] idx);
    logic signed [1:0] step;
    case (idx)
      4'd1, 4'd7, 4'd8, 4'd14: step = -2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: step = 2'sd1;
      default: step = 2'sd0;
    endcase
    return step;
  endfunction

endpackage

FILE: rtl/bdqd_button_lane.sv
// ----------------------------------------------------------------------------
// bdqd_button_lane
// Debounce and short/long press detection for one button.
// ----------------------------------------------------------------------------
module bdqd_button_lane #(
  parameter int unsigned TIME_BITS = bdqd_pkg::TIME_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  logic                   collect_i,
  input  logic                   level_i,
  input  logic [TIME_BITS-1:0]   now_i,
  input  logic [15:0]            debounce_i,
  input  logic [15:0]            long_i,
  output bdqd_pkg::lane_stat_t   stat_o
);

  logic                 last_level_q, last_level_d;
  logic [TIME_BITS-1:0] change_time_q, change_time_d;
  logic [TIME_BITS-1:0] press_time_q, press_time_d;
  logic                 pressed_q, pressed_d;
  logic                 long_sent_q, long_sent_d;
  bdqd_pkg::evt_e       pending_q, pending_d, pending_new;

  logic                 changed;
  logic [TIME_BITS-1:0] stable_for;
  logic [TIME_BITS-1:0] held_for;
  logic                 stable;
  logic                 act;

  // Time since the last level change and since the press was taken.
  assign changed    = (level_i != last_level_q);
  assign stable_for = changed ? '0 : (now_i - change_time_q);
  assign held_for   = now_i - press_time_q;
  assign stable     = (stable_for >= TIME_BITS'(debounce_i));

  // Press state update on a stable level.
  always_comb begin
    change_time_d = changed ? now_i : change_time_q;
    last_level_d  = level_i;
    press_time_d  = press_time_q;
    pressed_d     = pressed_q;
    long_sent_d   = long_sent_q;
    pending_new   = pending_q;
    act           = 1'b0;
    if (stable) begin
      if (!level_i && !pressed_q) begin
        pressed_d    = 1'b1;
        press_time_d = now_i;
        long_sent_d  = 1'b0;
        act          = 1'b1;
      end else if (!level_i && !long_sent_q) begin
        if (held_for >= TIME_BITS'(long_i)) begin
          pending_new = bdqd_pkg::EVT_LONG;
          long_sent_d = 1'b1;
          act         = 1'b1;
        end
      end else if (level_i && pressed_q) begin
        if (!long_sent_q) begin
          pending_new = bdqd_pkg::EVT_SHORT;
          act         = 1'b1;
        end
        pressed_d = 1'b0;
      end
    end
    pending_d = collect_i ? bdqd_pkg::EVT_NONE : pending_new;
  end

  assign stat_o.act = act;
  assign stat_o.evt = pending_new;

  // Lane state registers, updated once per accepted request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_level_q  <= 1'b1;
      change_time_q <= '0;
      press_time_q  <= '0;
      pressed_q     <= 1'b0;
      long_sent_q   <= 1'b0;
      pending_q     <= bdqd_pkg::EVT_NONE;
    end else if (accept_i) begin
      last_level_q  <= last_level_d;
      change_time_q <= change_time_d;
      press_time_q  <= press_time_d;
      pressed_q     <= pressed_d;
      long_sent_q   <= long_sent_d;
      pending_q     <= pending_d;
    end
  end

endmodule

FILE: rtl/bdqd_quad_lane.sv
// ----------------------------------------------------------------------------
// bdqd_quad_lane
// Quadrature decoder: step sum per transition and saturating detent count.
// ----------------------------------------------------------------------------
module bdqd_quad_lane (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic                 collect_i,
  input  logic                 quad_a_i,
  input  logic                 quad_b_i,
  output bdqd_pkg::quad_stat_t stat_o
);

  logic [1:0]        prev_q;
  logic signed [3:0] sum_q, sum_d, sum_next;
  logic signed [7:0] count_q, count_d, count_new;
  logic [1:0]        cur;
  logic              act;

  assign cur      = {quad_a_i, quad_b_i};
  assign sum_next = sum_q + 4'(bdqd_pkg::quad_step({prev_q, cur}));

  // A full detent clears the sum and moves the counter within its limits.
  always_comb begin
    sum_d     = sum_q;
    count_new = count_q;
    act       = 1'b0;
    if (cur != prev_q) begin
      sum_d = sum_next;
      if (sum_next >= bdqd_pkg::DETENT_UP) begin
        sum_d = '0;
        act   = 1'b1;
        if (count_q != bdqd_pkg::COUNT_MAX) begin
          count_new = count_q + 8'sd1;
        end
      end else if (sum_next <= bdqd_pkg::DETENT_DOWN) begin
        sum_d = '0;
        act   = 1'b1;
        if (count_q != bdqd_pkg::COUNT_MIN) begin
          count_new = count_q - 8'sd1;
        end
      end
    end
    count_d = collect_i ? 8'sd0 : count_new;
  end

  assign stat_o.act   = act;
  assign stat_o.count = count_new;

  // Encoder state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= 2'b11;
      sum_q   <= '0;
      count_q <= '0;
    end else if (accept_i) begin
      prev_q  <= cur;
      sum_q   <= sum_d;
      count_q <= count_d;
    end
  end

endmodule

FILE: rtl/bdqd_merge.sv
// ----------------------------------------------------------------------------
// bdqd_merge
// Combines the lane reports into one result and holds it in the output
// register until it is taken.
// ----------------------------------------------------------------------------
module bdqd_merge #(
  parameter int unsigned BUTTON_COUNT = bdqd_pkg::BUTTON_COUNT_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic                 collect_i,
  input  bdqd_pkg::lane_stat_t lane_stat_i [BUTTON_COUNT],
  input  bdqd_pkg::quad_stat_t quad_stat_i,
  output logic                 ready_o,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output logic                 activity_o,
  output logic [1:0]           left_event_o,
  output logic [1:0]           right_event_o,
  output logic [1:0]           knob_event_o,
  output logic signed [7:0]    movement_o
);

  localparam int unsigned SHOWN = bdqd_pkg::LEVEL_INPUTS;

  logic                  valid_q;
  logic                  act_any;
  logic [SHOWN-1:0][1:0] evt_shown;
  logic                  activity_q;
  logic [SHOWN-1:0][1:0] evt_q;
  logic signed [7:0]     movement_q;

  // Any lane activity makes the result active.
  always_comb begin
    act_any = quad_stat_i.act;
    for (int i = 0; i < BUTTON_COUNT; i++) begin
      act_any = act_any | lane_stat_i[i].act;
    end
  end

  // Event fields show the pending code only on a collect.
  for (genvar k = 0; k < SHOWN; k++) begin : g_evt
    if (k < BUTTON_COUNT) begin : g_lane
      assign evt_shown[k] = collect_i ? lane_stat_i[k].evt : bdqd_pkg::EVT_NONE;
    end else begin : g_none
      assign evt_shown[k] = bdqd_pkg::EVT_NONE;
    end
  end

  // The output register frees up when empty or when its result is taken.
  assign ready_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= accept_i;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      activity_q <= act_any;
      evt_q      <= evt_shown;
      movement_q <= collect_i ? quad_stat_i.count : 8'sd0;
    end
  end

  assign out_valid_o   = valid_q;
  assign activity_o    = activity_q;
  assign left_event_o  = evt_q[0];
  assign right_event_o = evt_q[1];
  assign knob_event_o  = evt_q[2];
  assign movement_o    = movement_q;

endmodule

FILE: rtl/button_debounce_and_quadrature_decode_unit.sv
// ----------------------------------------------------------------------------
// button_debounce_and_quadrature_decode_unit
// Debounces the button pins, reports short and long presses, and counts
// encoder detents, one pin sample per request.
// ----------------------------------------------------------------------------
// Results show in the output register in the cycle after acceptance. All
// button lanes and the encoder lane update their state in the same cycle the
// request is accepted, which sets the rate of one request per cycle while the
// output does not stall. While a result waits under stall, the unit still
// accepts a request in the cycle the result is taken. Configuration registers
// sit at byte addresses 0 (debounce time) and 4 (long press time); the user
// must write them only while idle, which the block does not enforce.
module button_debounce_and_quadrature_decode_unit #(
  parameter int unsigned TIME_BITS    = bdqd_pkg::TIME_BITS_DEF,
  parameter int unsigned BUTTON_COUNT = bdqd_pkg::BUTTON_COUNT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Configuration port.
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // Sample request channel.
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [31:0]       now_ms_i,
  input  logic              left_level_i,
  input  logic              right_level_i,
  input  logic              knob_switch_level_i,
  input  logic              quad_a_i,
  input  logic              quad_b_i,
  input  logic              collect_i,
  // Result channel.
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              activity_o,
  output logic [1:0]        left_event_o,
  output logic [1:0]        right_event_o,
  output logic [1:0]        knob_event_o,
  output logic signed [7:0] movement_o
);

  logic [15:0] debounce_q;
  logic [15:0] long_q;
  logic        cfg_wr;
  logic        ready;
  logic        accept;

  logic [TIME_BITS-1:0]                   now_t;
  logic [bdqd_pkg::LEVEL_INPUTS-1:0]      level_pins;
  bdqd_pkg::lane_stat_t                   lane_stat [BUTTON_COUNT];
  bdqd_pkg::quad_stat_t                   quad_stat;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= bdqd_pkg::DEBOUNCE_RESET;
      long_q     <= bdqd_pkg::LONG_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        bdqd_pkg::REG_DEBOUNCE: debounce_q <= pwdata[15:0];
        bdqd_pkg::REG_LONG:     long_q     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      bdqd_pkg::REG_DEBOUNCE: prdata = {16'd0, debounce_q};
      bdqd_pkg::REG_LONG:     prdata = {16'd0, long_q};
      default:                prdata = '0;
    endcase
  end

  // Request handshake.
  assign in_stall_o = !ready;
  assign accept     = in_valid_i && ready;

  assign now_t      = TIME_BITS'(now_ms_i);
  assign level_pins = {knob_switch_level_i, right_level_i, left_level_i};

  // One debounce lane per button; buttons without a pin read as released.
  for (genvar i = 0; i < BUTTON_COUNT; i++) begin : g_lane
    logic lvl;
    if (i < bdqd_pkg::LEVEL_INPUTS) begin : g_pin
      assign lvl = level_pins[i];
    end else begin : g_idle
      assign lvl = 1'b1;
    end

    bdqd_button_lane #(
      .TIME_BITS (TIME_BITS)
    ) u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .accept_i   (accept),
      .collect_i  (collect_i),
      .level_i    (lvl),
      .now_i      (now_t),
      .debounce_i (debounce_q),
      .long_i     (long_q),
      .stat_o     (lane_stat[i])
    );
  end

  // Encoder lane.
  bdqd_quad_lane u_quad (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .collect_i (collect_i),
    .quad_a_i  (quad_a_i),
    .quad_b_i  (quad_b_i),
    .stat_o    (quad_stat)
  );

  // Merge and output register.
  bdqd_merge #(
    .BUTTON_COUNT (BUTTON_COUNT)
  ) u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .collect_i     (collect_i),
    .lane_stat_i   (lane_stat),
    .quad_stat_i   (quad_stat),
    .ready_o       (ready),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .activity_o    (activity_o),
    .left_event_o  (left_event_o),
    .right_event_o (right_event_o),
    .knob_event_o  (knob_event_o),
    .movement_o    (movement_o)
  );

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the button debounce and quadrature decode unit. A
// scoreboard class keeps its own copy of the debounce, press and detent state,
// predicts one report per accepted pin sample and compares each delivered
// report field by field. Plain tasks drive directed samples, random press and
// encoder sequences and long encoder spins under several timing settings.
// ----------------------------------------------------------------------------
module tb_top;

  // Byte addresses of the timing registers.
  localparam logic [2:0] ADDR_DEBOUNCE = {bdqd_pkg::REG_DEBOUNCE, 2'b00};
  localparam logic [2:0] ADDR_LONG     = {bdqd_pkg::REG_LONG, 2'b00};

  // Cycles without any accepted request or report before the run is abandoned.
  localparam int WATCHDOG_LIMIT = 4000;

  // Step value per {previous, current} contact pair; invalid jumps give zero.
  localparam int QUAD_STEP [16] = '{0, -1, 1, 0, 1, 0, 0, -1, -1, 0, 0, 1, 0, 1, -1, 0};

  // Contact pairs along one forward revolution of the encoder.
  localparam logic [1:0] GRAY_POS [4] = '{2'b11, 2'b01, 2'b00, 2'b10};

  typedef struct packed {
    logic [31:0] now_ms;
    logic        left;
    logic        right;
    logic        knob;
    logic        quad_a;
    logic        quad_b;
    logic        collect;
  } pin_sample_t;

  typedef struct packed {
    logic              activity;
    logic [1:0]        left_event;
    logic [1:0]        right_event;
    logic [1:0]        knob_event;
    logic signed [7:0] movement;
  } press_report_t;

  // Scoreboard: predicts the report of every accepted sample and checks the
  // reports in order.
  class press_detent_scoreboard;
    logic [15:0]       settle_ms;
    logic [15:0]       long_ms;
    logic              seen_level [bdqd_pkg::BUTTON_COUNT_DEF];
    logic [31:0]       change_ms  [bdqd_pkg::BUTTON_COUNT_DEF];
    logic [31:0]       press_ms   [bdqd_pkg::BUTTON_COUNT_DEF];
    logic              pressed    [bdqd_pkg::BUTTON_COUNT_DEF];
    logic              long_fired [bdqd_pkg::BUTTON_COUNT_DEF];
    bdqd_pkg::evt_e    pending    [bdqd_pkg::BUTTON_COUNT_DEF];
    logic [1:0]        contacts;
    logic signed [3:0] quarter_sum;
    logic signed [7:0] detents;
    press_report_t     awaited [$];
    int                errors;

    function new();
      settle_ms = bdqd_pkg::DEBOUNCE_RESET;
      long_ms   = bdqd_pkg::LONG_RESET;
      for (int i = 0; i < bdqd_pkg::BUTTON_COUNT_DEF; i++) begin
        seen_level[i] = 1'b1;
        change_ms[i]  = '0;
        press_ms[i]   = '0;
        pressed[i]    = 1'b0;
        long_fired[i] = 1'b0;
        pending[i]    = bdqd_pkg::EVT_NONE;
      end
      contacts    = 2'b11;
      quarter_sum = '0;
      detents     = '0;
      errors      = 0;
    endfunction

    // Debounce one button and advance its press state; returns activity.
    function bit button_update(int i, logic level, logic [31:0] now);
      logic [31:0] since;
      if (level != seen_level[i]) change_ms[i] = now;
      seen_level[i] = level;
      since = now - change_ms[i];
      if (since < {16'd0, settle_ms}) return 1'b0;
      if (!level && !pressed[i]) begin
        pressed[i]    = 1'b1;
        press_ms[i]   = now;
        long_fired[i] = 1'b0;
        return 1'b1;
      end
      if (!level && !long_fired[i]) begin
        since = now - press_ms[i];
        if (since >= {16'd0, long_ms}) begin
          pending[i]    = bdqd_pkg::EVT_LONG;
          long_fired[i] = 1'b1;
          return 1'b1;
        end
        return 1'b0;
      end
      if (level && pressed[i]) begin
        pressed[i] = 1'b0;
        if (!long_fired[i]) begin
          pending[i] = bdqd_pkg::EVT_SHORT;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    // Accumulate quarter steps and move the saturating detent count.
    function bit encoder_update(logic a, logic b);
      logic [1:0] pair;
      int         step;
      pair = {a, b};
      if (pair == contacts) return 1'b0;
      step = QUAD_STEP[{contacts, pair}];
      contacts = pair;
      if (step > 0) quarter_sum = quarter_sum + 4'sd1;
      else if (step < 0) quarter_sum = quarter_sum - 4'sd1;
      if (quarter_sum >= bdqd_pkg::DETENT_UP) begin
        quarter_sum = '0;
        if (detents != bdqd_pkg::COUNT_MAX) detents = detents + 8'sd1;
        return 1'b1;
      end
      if (quarter_sum <= bdqd_pkg::DETENT_DOWN) begin
        quarter_sum = '0;
        if (detents != bdqd_pkg::COUNT_MIN) detents = detents - 8'sd1;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_sample(pin_sample_t s);
      press_report_t rep;
      logic          levels [bdqd_pkg::BUTTON_COUNT_DEF];
      bit            act;
      levels = '{s.left, s.right, s.knob};
      act = 1'b0;
      for (int i = 0; i < bdqd_pkg::BUTTON_COUNT_DEF; i++) begin
        if (button_update(i, levels[i], s.now_ms)) act = 1'b1;
      end
      if (encoder_update(s.quad_a, s.quad_b)) act = 1'b1;
      rep.activity = act;
      if (s.collect) begin
        rep.left_event  = pending[0];
        rep.right_event = pending[1];
        rep.knob_event  = pending[2];
        rep.movement    = detents;
        for (int i = 0; i < bdqd_pkg::BUTTON_COUNT_DEF; i++) pending[i] = bdqd_pkg::EVT_NONE;
        detents = '0;
      end else begin
        rep.left_event  = bdqd_pkg::EVT_NONE;
        rep.right_event = bdqd_pkg::EVT_NONE;
        rep.knob_event  = bdqd_pkg::EVT_NONE;
        rep.movement    = '0;
      end
      awaited.push_back(rep);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_report(press_report_t got);
      press_report_t want;
      if (awaited.size() == 0) begin
        $error("report delivered with no request outstanding");
        errors++;
        return;
      end
      want = awaited.pop_front();
      compare_field("activity", 8'(want.activity), 8'(got.activity));
      compare_field("left_event", 8'(want.left_event), 8'(got.left_event));
      compare_field("right_event", 8'(want.right_event), 8'(got.right_event));
      compare_field("knob_event", 8'(want.knob_event), 8'(got.knob_event));
      compare_field("movement", want.movement, got.movement);
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [2:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [31:0]       now_ms_i;
  logic              left_level_i;
  logic              right_level_i;
  logic              knob_switch_level_i;
  logic              quad_a_i;
  logic              quad_b_i;
  logic              collect_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic              activity_o;
  logic [1:0]        left_event_o;
  logic [1:0]        right_event_o;
  logic [1:0]        knob_event_o;
  logic signed [7:0] movement_o;

  press_detent_scoreboard sb;

  // Stimulus state shared by the driving tasks.
  logic [31:0] clock_ms;
  logic        btn_hold [3];
  int          enc_pos;
  bit          gaps_on;
  logic [15:0] cfg_debounce;
  logic [15:0] cfg_long;
  int          idle_cycles;

  always #2 clk_i = ~clk_i;

  button_debounce_and_quadrature_decode_unit i_dut (.*);

  // Monitor both channels and feed the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_stall_o === 1'b0) begin
        sb.note_sample(pin_sample_t'{now_ms_i, left_level_i, right_level_i,
                                     knob_switch_level_i, quad_a_i, quad_b_i, collect_i});
      end
      if (out_valid_o === 1'b1 && !out_stall_i) begin
        sb.check_report(press_report_t'{activity_o, left_event_o, right_event_o,
                                        knob_event_o, movement_o});
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a request.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_stall_o === 1'b0) ||
        (out_valid_o === 1'b1 && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: free-running stretches, short stalls and a few long ones.
  initial begin : receiver
    int mode;
    int len;
    out_stall_i <= 1'b0;
    @(posedge clk_i);
    forever begin
      mode = $urandom_range(0, 9);
      if (mode < 2) begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(10, 60)) @(posedge clk_i);
      end else begin
        len = (mode == 9) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        out_stall_i <= 1'b1;
        repeat (len) @(posedge clk_i);
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end
    end
  end

  // Present one sample and hold it until accepted, then maybe idle a while.
  task automatic send_pins(logic [31:0] t, logic l, logic r, logic k,
                           logic a, logic b, logic c);
    int roll;
    int gap;
    in_valid_i          <= 1'b1;
    now_ms_i            <= t;
    left_level_i        <= l;
    right_level_i       <= r;
    knob_switch_level_i <= k;
    quad_a_i            <= a;
    quad_b_i            <= b;
    collect_i           <= c;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    gap = 0;
    if (gaps_on) begin
      roll = $urandom_range(0, 99);
      if (roll >= 95) gap = $urandom_range(10, 40);
      else if (roll >= 60) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop sending and let every outstanding report drain.
  task automatic drain_reports();
    in_valid_i <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Two-phase register write on the configuration port.
  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_timing(logic [15:0] debounce, logic [15:0] long_hold);
    drain_reports();
    reg_write(ADDR_DEBOUNCE, {16'd0, debounce});
    reg_write(ADDR_LONG, {16'd0, long_hold});
    sb.settle_ms = debounce;
    sb.long_ms   = long_hold;
    cfg_debounce = debounce;
    cfg_long     = long_hold;
  endtask

  // Random press and encoder traffic with bounce noise and timestamp jumps.
  task automatic run_random(int count);
    logic       lv [3];
    logic [1:0] pair;
    int         roll;
    int         span;
    int         dir;
    span = (int'(cfg_debounce) + int'(cfg_long)) / 8 + 2;
    dir  = $urandom_range(0, 1) ? 1 : -1;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 4) clock_ms = $urandom();
      else if (roll >= 15) clock_ms = clock_ms + $urandom_range(0, span);
      for (int i = 0; i < 3; i++) begin
        if ($urandom_range(0, 9) == 0) btn_hold[i] = ~btn_hold[i];
        lv[i] = btn_hold[i] ^ ($urandom_range(0, 11) == 0);
      end
      roll = $urandom_range(0, 99);
      if (roll < 60) enc_pos = (enc_pos + dir + 4) % 4;
      else if (roll < 75) enc_pos = (enc_pos - dir + 4) % 4;
      else if (roll < 80) enc_pos = (enc_pos + 2) % 4;
      pair = GRAY_POS[enc_pos];
      send_pins(clock_ms, lv[0], lv[1], lv[2], pair[1], pair[0],
                $urandom_range(0, 5) == 0);
    end
  endtask

  // Turn the encoder steadily in one direction, then collect the count.
  task automatic spin_encoder(int detent_steps, int dir);
    logic [1:0] pair;
    for (int n = 0; n < 4 * detent_steps; n++) begin
      enc_pos  = (enc_pos + dir + 4) % 4;
      pair     = GRAY_POS[enc_pos];
      clock_ms = clock_ms + $urandom_range(0, 3);
      send_pins(clock_ms, 1'b1, 1'b1, 1'b1, pair[1], pair[0], 1'b0);
    end
    pair = GRAY_POS[enc_pos];
    send_pins(clock_ms, 1'b1, 1'b1, 1'b1, pair[1], pair[0], 1'b1);
  endtask

  initial begin : stimulus
    sb = new();
    rst_ni              <= 1'b0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    in_valid_i          <= 1'b0;
    now_ms_i            <= '0;
    left_level_i        <= 1'b1;
    right_level_i       <= 1'b1;
    knob_switch_level_i <= 1'b1;
    quad_a_i            <= 1'b1;
    quad_b_i            <= 1'b1;
    collect_i           <= 1'b0;
    btn_hold     = '{1'b1, 1'b1, 1'b1};
    cfg_debounce = bdqd_pkg::DEBOUNCE_RESET;
    cfg_long     = bdqd_pkg::LONG_RESET;
    gaps_on      = 1'b1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Left button: stable press, long press, release with no second event.
    send_pins(32'd0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
    send_pins(32'd0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
    send_pins(32'd60, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
    send_pins(32'd1100, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
    send_pins(32'd1101, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
    // Right and knob: short presses, the knob with a bounce on release.
    send_pins(32'd1200, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0);
    send_pins(32'd1260, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0);
    send_pins(32'd1300, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
    send_pins(32'd1300, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0);
    send_pins(32'd1360, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
    send_pins(32'd1420, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
    // One forward detent, a step back, an invalid jump, then collect.
    send_pins(32'd1421, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0);
    send_pins(32'd1422, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
    send_pins(32'd1423, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
    send_pins(32'd1424, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
    send_pins(32'd1425, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
    send_pins(32'd1426, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0);
    send_pins(32'd1427, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1);
    // Debounce across the timestamp wrap, through the largest timestamp.
    send_pins(32'hFFFF_FFE0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
    send_pins(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
    send_pins(32'h0000_0020, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
    send_pins(32'h0000_0030, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
    send_pins(32'h0000_0070, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1);
    enc_pos  = 2;
    clock_ms = 32'h0000_0070;

    // Random traffic under a range of timing settings, extremes included.
    set_timing(16'd3, 16'd12);
    run_random(40);
    gaps_on = 1'b0;
    set_timing(16'd0, 16'd0);
    run_random(30);
    gaps_on = 1'b1;
    set_timing(16'hFFFF, 16'hFFFF);
    run_random(30);
    gaps_on = 1'b0;
    set_timing(16'd0, 16'hFFFF);
    run_random(30);
    set_timing(16'd9, 16'd40);
    run_random(40);
    gaps_on = 1'b1;
    set_timing(16'd1, 16'd3);
    run_random(35);

    // Steady spins in both directions, each read out at the end.
    set_timing(bdqd_pkg::DEBOUNCE_RESET, bdqd_pkg::LONG_RESET);
    spin_encoder(20, 1);
    spin_encoder(20, -1);

    drain_reports();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: button_debounce_and_quadrature_decode_unit.f
rtl/bdqd_pkg.sv
rtl/bdqd_button_lane.sv
rtl/bdqd_quad_lane.sv
rtl/bdqd_merge.sv
rtl/button_debounce_and_quadrature_decode_unit.sv
test/tb_top.sv
